>>> hdl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types, codes and defaults for the linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int KEY_W          = 32;
  localparam int DATA_W         = 32;
  localparam int CMD_W          = 3;
  localparam int ST_W           = 2;
  localparam int LEN_W          = 7;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic signed [KEY_W-1:0]  key_value;
    logic signed [KEY_W-1:0]  new_key;
    logic signed [DATA_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [KEY_W-1:0]  removed_key;
    logic signed [DATA_W-1:0] removed_data;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_HIT, OP_NEXT, OP_SETST, OP_FRESH, OP_POP,
    OP_TAKE, OP_LINK1, OP_LINK2, OP_UNL1, OP_UNL2, OP_OUT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ST_W-1:0] st;
    logic            idle;
  } ctl_cmd_t;

  typedef struct packed {
    logic             req_valid;
    logic [CMD_W-1:0] cmd;
    logic             head_nil;
    logic             match;
    logic             nx_nil;
    logic             full;
    logic             ret_empty;
    logic             out_free;
  } dp_stat_t;

endpackage

>>> hdl/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dll_ctrl.sv
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer for list commands: dispatch, key walk, allocation, link updates.
// ----------------------------------------------------------------------------
module dll_ctrl import dll_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_CK, S_ALLOC, S_TAKE, S_LINK1, S_LINK2,
    S_UNL1, S_UNL2, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.st     = ST_OK;
    cmd.idle   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (stat.req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.cmd == CMD_INS_FRONT || stat.cmd == CMD_INS_BACK) begin
          state_next = S_ALLOC;
        end else if (stat.cmd == CMD_DEL_FRONT || stat.cmd == CMD_DEL_BACK ||
                     stat.cmd == CMD_DEL_KEY || stat.cmd == CMD_INS_AFTER) begin
          if (stat.head_nil) begin
            cmd.op     = OP_SETST;
            cmd.st     = ST_EMPTY;
            state_next = S_DONE;
          end else begin
            cmd.op     = OP_START;
            state_next = S_RD;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_RD: state_next = S_CK;
      S_CK: begin
        if (stat.match) begin
          cmd.op     = OP_HIT;
          state_next = (stat.cmd == CMD_INS_AFTER) ? S_ALLOC : S_UNL1;
        end else if (stat.nx_nil) begin
          cmd.op     = OP_SETST;
          cmd.st     = ST_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_NEXT;
          state_next = S_RD;
        end
      end
      S_ALLOC: begin
        if (stat.full) begin
          cmd.op     = OP_SETST;
          cmd.st     = ST_FULL;
          state_next = S_DONE;
        end else if (stat.ret_empty) begin
          cmd.op     = OP_FRESH;
          state_next = S_LINK1;
        end else begin
          cmd.op     = OP_POP;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_LINK1;
      end
      S_LINK1: begin
        cmd.op     = OP_LINK1;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        cmd.op     = OP_LINK2;
        state_next = S_DONE;
      end
      S_UNL1: begin
        cmd.op     = OP_UNL1;
        state_next = S_UNL2;
      end
      S_UNL2: begin
        cmd.op     = OP_UNL2;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/dll_dp.sv
// ----------------------------------------------------------------------------
// dll_dp
// Datapath: node memories, free stack, head/tail/count and result register.
// ----------------------------------------------------------------------------
module dll_dp import dll_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  input  logic     req_valid,
  output logic     req_stall,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  req_t            req_r;
  logic [LW-1:0]   head, tail, count, fresh, ret_cnt;
  logic [LW-1:0]   cur, at, nx, pv;
  logic [IW-1:0]   node;
  logic [ST_W-1:0] st;
  logic [KEY_W-1:0]  hit_key;
  logic [DATA_W-1:0] hit_data;

  logic [KEY_W-1:0]  key_rd;
  logic [DATA_W-1:0] data_rd;
  logic [LW-1:0]     next_rd, prev_rd;
  logic [IW-1:0]     free_rd;

  logic              key_we, next_we, prev_we, free_we;
  logic [IW-1:0]     next_wa, prev_wa;
  logic [LW-1:0]     next_wd, prev_wd;
  logic [LW-1:0]     node_l;
  logic              del_cmd;

  assign node_l  = LW'(node);
  assign del_cmd = (req_r.cmd == CMD_DEL_FRONT) || (req_r.cmd == CMD_DEL_BACK) ||
                   (req_r.cmd == CMD_DEL_KEY);

  assign req_stall      = !cmd.idle;
  assign stat.req_valid = req_valid;
  assign stat.cmd       = req_r.cmd;
  assign stat.head_nil  = (head == NIL);
  assign stat.match     = (req_r.cmd != CMD_DEL_KEY && req_r.cmd != CMD_INS_AFTER) ||
                          (key_rd == req_r.key_value);
  assign stat.nx_nil    = (next_rd == NIL);
  assign stat.full      = (fresh == NIL) && (ret_cnt == '0);
  assign stat.ret_empty = (ret_cnt == '0);
  assign stat.out_free  = !rsp_valid || !rsp_stall;

  assign key_we  = (cmd.op == OP_LINK1);
  assign free_we = (cmd.op == OP_UNL1);

  always_comb begin
    next_we = 1'b0;
    next_wa = node;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = node;
    prev_wd = NIL;
    case (cmd.op)
      OP_LINK1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        if (req_r.cmd == CMD_INS_FRONT) begin
          next_wd = head;
        end else if (req_r.cmd == CMD_INS_BACK) begin
          prev_wd = tail;
        end else begin
          next_wd = nx;
          prev_wd = at;
        end
      end
      OP_LINK2: begin
        next_wd = node_l;
        prev_wd = node_l;
        if (req_r.cmd == CMD_INS_FRONT) begin
          prev_we = (head != NIL);
          prev_wa = head[IW-1:0];
        end else if (req_r.cmd == CMD_INS_BACK) begin
          next_we = (tail != NIL);
          next_wa = tail[IW-1:0];
        end else begin
          next_we = 1'b1;
          next_wa = at[IW-1:0];
          prev_we = (nx != NIL);
          prev_wa = nx[IW-1:0];
        end
      end
      OP_UNL1: begin
        next_we = (pv != NIL);
        next_wa = pv[IW-1:0];
        next_wd = nx;
      end
      OP_UNL2: begin
        prev_we = (nx != NIL);
        prev_wa = nx[IW-1:0];
        prev_wd = pv;
      end
      default: ;
    endcase
  end

  dll_ram #(.WIDTH(KEY_W), .DEPTH(POOL_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(node),
    .wdata((req_r.cmd == CMD_INS_AFTER) ? req_r.new_key : req_r.key_value),
    .raddr(cur[IW-1:0]), .rdata(key_rd)
  );

  dll_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_data_ram (
    .clk(clk), .we(key_we), .waddr(node), .wdata(req_r.data_value),
    .raddr(cur[IW-1:0]), .rdata(data_rd)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(cur[IW-1:0]), .rdata(next_rd)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(cur[IW-1:0]), .rdata(prev_rd)
  );

  // returned nodes; never-used nodes come from the fresh counter
  dll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(ret_cnt[IW-1:0]), .wdata(at[IW-1:0]),
    .raddr(IW'(ret_cnt - LW'(1))), .rdata(free_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      count     <= '0;
      fresh     <= '0;
      ret_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (cmd.op == OP_OUT) || (rsp_valid && rsp_stall);
      case (cmd.op)
        OP_FRESH: fresh   <= fresh + LW'(1);
        OP_POP:   ret_cnt <= ret_cnt - LW'(1);
        OP_LINK2: begin
          count <= count + LW'(1);
          if (req_r.cmd == CMD_INS_FRONT) begin
            head <= node_l;
            if (head == NIL) tail <= node_l;
          end else if (req_r.cmd == CMD_INS_BACK) begin
            tail <= node_l;
            if (tail == NIL) head <= node_l;
          end else if (nx == NIL) begin
            tail <= node_l;
          end
        end
        OP_UNL1: begin
          ret_cnt <= ret_cnt + LW'(1);
          if (pv == NIL) head <= nx;
        end
        OP_UNL2: begin
          count <= count - LW'(1);
          if (nx == NIL) tail <= pv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r <= req;
        st    <= ST_OK;
      end
      OP_START: cur <= (req_r.cmd == CMD_DEL_BACK) ? tail : head;
      OP_NEXT:  cur <= next_rd;
      OP_HIT: begin
        at       <= cur;
        nx       <= next_rd;
        pv       <= prev_rd;
        hit_key  <= key_rd;
        hit_data <= data_rd;
      end
      OP_SETST: st   <= cmd.st;
      OP_FRESH: node <= fresh[IW-1:0];
      OP_TAKE:  node <= free_rd;
      OP_OUT: begin
        rsp.status       <= st;
        rsp.removed_key  <= (del_cmd && st == ST_OK) ? hit_key : '0;
        rsp.removed_data <= (del_cmd && st == ST_OK) ? hit_data : '0;
        rsp.list_length  <= LEN_W'(count);
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_unit
// Doubly linked list of key/data nodes in a fixed pool with a free stack.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | req_t (cmd, keys, data)
//   rsp     | out       | rsp_valid/stall  | rsp_t (status, removed, length)
//
// One request at a time. Inserts that reuse a returned node pass through an
// extra take state; key commands walk the list with one RAM read and compare
// per node walked.
// No clearing pass after reset: never-used nodes are issued by a counter.
// A stalled response holds the engine in its final state.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_unit import dll_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .cmd(cmd)
  );

  dll_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Linked list engine check: directed and random command streams, with a
// scoreboard that keeps its own list and predicts every response.
// ----------------------------------------------------------------------------
module tb_top;
  import dll_pkg::*;

  localparam int DEPTH = POOL_DEPTH_DEF;
  localparam int NIL   = DEPTH;
  localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

  class list_scoreboard;
    logic [KEY_W-1:0]  keys [DEPTH];
    logic [DATA_W-1:0] data [DEPTH];
    int                nxt  [DEPTH];
    int                prv  [DEPTH];
    int                free_q[$];
    int                head, tail, count;
    rsp_t              pending[$];
    int                errors, checked;
    int                st_seen[4];

    function new();
      head = NIL; tail = NIL; count = 0;
      for (int i = DEPTH - 1; i >= 0; i--) free_q.push_back(i);
      errors = 0; checked = 0;
    endfunction

    function int find(logic [KEY_W-1:0] k);
      int cur;
      cur = head;
      for (int s = 0; s < DEPTH && cur != NIL; s++) begin
        if (keys[cur] == k) return cur;
        cur = nxt[cur];
      end
      return NIL;
    endfunction

    function void unlink(int i);
      if (prv[i] != NIL) nxt[prv[i]] = nxt[i]; else head = nxt[i];
      if (nxt[i] != NIL) prv[nxt[i]] = prv[i]; else tail = prv[i];
      count--;
      free_q.push_back(i);
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   n, at;
      e = '0;
      e.status = ST_OK;
      case (r.cmd)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (free_q.size() == 0) e.status = ST_FULL;
          else begin
            n = free_q.pop_back();
            keys[n] = r.key_value; data[n] = r.data_value;
            if (r.cmd == CMD_INS_FRONT) begin
              prv[n] = NIL; nxt[n] = head;
              if (head != NIL) prv[head] = n; else tail = n;
              head = n;
            end else begin
              nxt[n] = NIL; prv[n] = tail;
              if (tail != NIL) nxt[tail] = n; else head = n;
              tail = n;
            end
            count++;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_KEY: begin
          if (head == NIL) e.status = ST_EMPTY;
          else begin
            at = (r.cmd == CMD_DEL_FRONT) ? head :
                 (r.cmd == CMD_DEL_BACK) ? tail : find(r.key_value);
            if (at == NIL) e.status = ST_NOT_FOUND;
            else begin
              e.removed_key = keys[at]; e.removed_data = data[at];
              unlink(at);
            end
          end
        end
        CMD_INS_AFTER: begin
          if (head == NIL) e.status = ST_EMPTY;
          else begin
            at = find(r.key_value);
            if (at == NIL) e.status = ST_NOT_FOUND;
            else if (free_q.size() == 0) e.status = ST_FULL;
            else begin
              n = free_q.pop_back();
              keys[n] = r.new_key; data[n] = r.data_value;
              prv[n] = at; nxt[n] = nxt[at];
              if (nxt[at] != NIL) prv[nxt[at]] = n; else tail = n;
              nxt[at] = n;
              count++;
            end
          end
        end
        default: ;
      endcase
      e.list_length = count[LEN_W-1:0];
      st_seen[e.status]++;
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.removed_key !== e.removed_key) begin
        $error("removed_key exp %0h got %0h", e.removed_key, a.removed_key); errors++;
      end
      if (a.removed_data !== e.removed_data) begin
        $error("removed_data exp %0h got %0h", e.removed_data, a.removed_data); errors++;
      end
      if (a.list_length !== e.list_length) begin
        $error("list_length exp %0d got %0d", e.list_length, a.list_length); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  req_t req;
  rsp_t rsp;
  list_scoreboard sb;
  bit   long_hold;
  logic [KEY_W-1:0] used_keys[$];

  doubly_linked_list_engine_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                              logic [KEY_W-1:0] nk, logic [DATA_W-1:0] d);
    int g;
    req_valid <= 1'b1;
    req <= '{cmd: c, key_value: k, new_key: nk, data_value: d};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(req);
    if (c <= CMD_INS_AFTER) used_keys.push_back(k);
    if (used_keys.size() > 32) void'(used_keys.pop_front());
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return $urandom_range(0, 15);
  endfunction

  task automatic random_request(int fill_bias);
    logic [CMD_W-1:0] c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) c = p[0] ? CMD_RSV7 : CMD_RSV6;
    else if (p < fill_bias) c = (p % 3 == 0) ? CMD_INS_AFTER : (p[0] ? CMD_INS_BACK : CMD_INS_FRONT);
    else c = CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_DEL_KEY));
    if ($urandom_range(0, 19) == 0)
      send_request(c, $urandom(), $urandom(), $urandom());
    else
      send_request(c, pick_key(), pick_key(), $urandom());
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  initial begin
    int h;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp_stall <= 1'b1;
        for (h = 0; h < 300; h++) @(posedge clk);
        long_hold = 1'b0;
        rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 3) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else rsp_stall <= 1'b0;
    end
  end

  initial begin
    logic [KEY_W-1:0] kmin, kmax;
    sb = new();
    long_hold = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    kmin = 32'h8000_0000; kmax = 32'h7fff_ffff;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list cases
    send_request(CMD_DEL_FRONT, 0, 0, 0);
    send_request(CMD_DEL_BACK, 0, 0, 0);
    send_request(CMD_DEL_KEY, 5, 0, 0);
    send_request(CMD_INS_AFTER, 5, 1, 1);
    send_request(CMD_RSV6, 1, 1, 1);
    send_request(CMD_RSV7, 1, 1, 1);
    // extremes and each operation
    send_request(CMD_INS_FRONT, kmin, kmax, kmax);
    send_request(CMD_INS_BACK, kmax, kmin, kmin);
    send_request(CMD_INS_FRONT, 32'hffff_ffff, 0, 32'hffff_ffff);
    send_request(CMD_INS_AFTER, kmin, 32'h0, 32'h5555_aaaa);
    send_request(CMD_INS_AFTER, kmax, 32'h1234, 32'haaaa_5555);
    send_request(CMD_INS_AFTER, 99, 1, 1);
    send_request(CMD_DEL_KEY, 99, 0, 0);
    send_request(CMD_DEL_KEY, 32'h1234, 0, 0);
    send_request(CMD_DEL_KEY, 32'h0, 0, 0);
    send_request(CMD_DEL_FRONT, 0, 0, 0);
    send_request(CMD_DEL_BACK, 0, 0, 0);
    send_request(CMD_INS_BACK, 7, 0, 70);
    send_request(CMD_INS_BACK, 7, 0, 71);
    send_request(CMD_DEL_KEY, 7, 0, 0);
    send_request(CMD_DEL_FRONT, 0, 0, 0);
    send_request(CMD_DEL_FRONT, 0, 0, 0);
    drain();

    // fill to the pool limit, with the response side held off at the start
    long_hold = 1'b1;
    for (int i = 0; i < 75; i++) send_request(CMD_INS_BACK, i % 20, 0, $urandom());
    send_request(CMD_INS_AFTER, 3, 500, 1);
    send_request(CMD_INS_FRONT, 1, 0, 1);
    drain();

    for (int i = 0; i < 1000; i++) begin
      random_request((i / 150) % 2 == 0 ? 70 : 40);
      if (i == 500) drain();
    end
    drain();

    $display("Checked %0d responses: ok %0d, empty %0d, not found %0d, full %0d",
             sb.checked, sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
